[rtl/lbf_pkg.sv]
// Shared types, sizes and Bernstein weight tables for the link Bezier flattener.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lbf_pkg;

    // Samples per link, clamped to the supported range of 2..64.
    localparam int SEGMENT_POINTS = 16;
    localparam int SEG_POINTS = (SEGMENT_POINTS < 2) ? 2 :
                                ((SEGMENT_POINTS > 64) ? 64 : SEGMENT_POINTS);
    localparam int SEG_N      = SEG_POINTS - 1;
    localparam longint DEN    = longint'(SEG_N) * SEG_N * SEG_N;
    localparam int IDX_W      = $clog2(SEG_POINTS);

    localparam int COORD_W = 24;
    localparam int FACT_W  = 9;
    localparam int PIDX_W  = 6;
    localparam int SUM_W   = COORD_W + 1;   // start/end plus shift
    localparam int DX_W    = COORD_W;       // |end_x - start_x|
    localparam int WT_W    = 18;            // summed weights, up to 65536 + rounding
    localparam int WS_W    = 17;            // single weight, 0..65536
    localparam int KP_W    = WS_W + FACT_W; // weight times factor
    localparam int KX_W    = KP_W + 1;      // signed difference of two such products
    localparam int PR_W    = WT_W + 1 + SUM_W;  // weight times coordinate
    localparam int PS_W    = PR_W + 1;          // sum of two such products
    localparam int DK_W    = DX_W + 1 + KX_W;   // dx times weighted factor difference
    localparam int ACC_W   = 54;                // Q.24 accumulator
    localparam int RND_W   = ACC_W - 16;        // after dropping 16 fraction bits

    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;

    // Table selectors
    localparam int WSEL_HEAD = 0;   // w1 + w2, weight on P0
    localparam int WSEL_TAIL = 1;   // w3 + w4, weight on P3
    localparam int WSEL_W2   = 2;
    localparam int WSEL_W3   = 3;

    typedef logic [WT_W-1:0] wtab_t [SEG_POINTS];

    // round(num * 65536 / DEN), ties upward
    function automatic longint bweight(input longint num);
        return (num * 131072 + DEN) / (2 * DEN);
    endfunction

    function automatic wtab_t build_wtab(input int sel);
        wtab_t  tab;
        longint t;
        longint u;
        longint w;
        for (int i = 0; i < SEG_POINTS; i++) begin
            t = i;
            u = SEG_N - i;
            case (sel)
                WSEL_HEAD: w = bweight(u * u * u) + bweight(3 * u * u * t);
                WSEL_TAIL: w = bweight(3 * u * t * t) + bweight(t * t * t);
                WSEL_W2:   w = bweight(3 * u * u * t);
                default:   w = bweight(3 * u * t * t);
            endcase
            tab[i] = WT_W'(w);
        end
        return tab;
    endfunction

    localparam wtab_t W_HEAD_TAB = build_wtab(WSEL_HEAD);
    localparam wtab_t W_TAIL_TAB = build_wtab(WSEL_TAIL);
    localparam wtab_t W2_TAB     = build_wtab(WSEL_W2);
    localparam wtab_t W3_TAB     = build_wtab(WSEL_W3);

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] shift_x;
        logic signed [COORD_W-1:0] shift_y;
        logic        [FACT_W-1:0]  start_reach;
        logic        [FACT_W-1:0]  end_reach;
    } lbf_link_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic        [PIDX_W-1:0]  point_index;
        logic                      last_point;
    } lbf_point_t;

    // One sample issued by the sequencer
    typedef struct packed {
        logic                      valid;
        logic        [IDX_W-1:0]   idx;
        logic                      last;
        logic signed [SUM_W-1:0]   s0x;
        logic signed [SUM_W-1:0]   s0y;
        logic signed [SUM_W-1:0]   s3x;
        logic signed [SUM_W-1:0]   s3y;
        logic        [DX_W-1:0]    dx;
        logic        [FACT_W-1:0]  fa;
        logic        [FACT_W-1:0]  fb;
        logic        [WT_W-1:0]    w_head;
        logic        [WT_W-1:0]    w_tail;
        logic        [WS_W-1:0]    w2;
        logic        [WS_W-1:0]    w3;
    } lbf_issue_t;

    // Full-precision weighted sums, Q.24
    typedef struct packed {
        logic                      valid;
        logic        [IDX_W-1:0]   idx;
        logic                      last;
        logic signed [ACC_W-1:0]   acc_x;
        logic signed [ACC_W-1:0]   acc_y;
    } lbf_acc_t;

endpackage

`default_nettype wire

[rtl/lbf_seq.sv]
// Link sequencer: takes a request, holds its control data and issues one sample a cycle.
// Depends on lbf_pkg for the link type, issue type and weight tables.
`default_nettype none

module lbf_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire lbf_pkg::lbf_link_t link,
    output logic                    busy,
    output lbf_pkg::lbf_issue_t     issue
);
    import lbf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEG_POINTS - 1);

    logic                    active_reg, active_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [SUM_W-1:0] s0x_reg, s0y_reg, s3x_reg, s3y_reg;
    logic [DX_W-1:0]         dx_reg;
    logic [FACT_W-1:0]       fa_reg, fb_reg;
    logic                    at_last;
    logic                    accept;
    logic signed [SUM_W-1:0] diff;
    logic signed [SUM_W-1:0] diff_abs;

    logic                    issue_valid_reg;
    lbf_issue_t              issue_data_reg, issue_data_next;

    assign at_last = (idx_reg == LAST_IDX);
    // Free during the last sample so the next link follows without a gap.
    assign busy    = active_reg && !at_last;
    assign accept  = start && !busy;

    assign diff     = SUM_W'(link.end_x) - SUM_W'(link.start_x);
    assign diff_abs = diff[SUM_W-1] ? -diff : diff;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (accept)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (active_reg)
        begin
            if (at_last)
                active_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    // Link payload, loaded on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0x_reg <= SUM_W'(link.start_x) + SUM_W'(link.shift_x);
            s0y_reg <= SUM_W'(link.start_y) + SUM_W'(link.shift_y);
            s3x_reg <= SUM_W'(link.end_x) + SUM_W'(link.shift_x);
            s3y_reg <= SUM_W'(link.end_y) + SUM_W'(link.shift_y);
            dx_reg  <= diff_abs[DX_W-1:0];
            fa_reg  <= link.start_reach;
            fb_reg  <= link.end_reach;
        end
    end

    always_comb
    begin
        issue_data_next.valid  = 1'b1;
        issue_data_next.idx    = idx_reg;
        issue_data_next.last   = at_last;
        issue_data_next.s0x    = s0x_reg;
        issue_data_next.s0y    = s0y_reg;
        issue_data_next.s3x    = s3x_reg;
        issue_data_next.s3y    = s3y_reg;
        issue_data_next.dx     = dx_reg;
        issue_data_next.fa     = fa_reg;
        issue_data_next.fb     = fb_reg;
        issue_data_next.w_head = W_HEAD_TAB[idx_reg];
        issue_data_next.w_tail = W_TAIL_TAB[idx_reg];
        issue_data_next.w2     = W2_TAB[idx_reg][WS_W-1:0];
        issue_data_next.w3     = W3_TAB[idx_reg][WS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            issue_valid_reg <= 1'b0;
        else
            issue_valid_reg <= active_reg;
    end

    always_ff @(posedge clk)
    begin
        issue_data_reg <= issue_data_next;
    end

    always_comb
    begin
        issue       = issue_data_reg;
        issue.valid = issue_valid_reg;
    end

endmodule

`default_nettype wire

[rtl/lbf_mac.sv]
// Multiply-accumulate pipeline: three stages from issued sample to Q.24 weighted sums.
// Depends on lbf_pkg for the issue and accumulator types.
`default_nettype none

module lbf_mac (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lbf_pkg::lbf_issue_t issue,
    output lbf_pkg::lbf_acc_t        acc
);
    import lbf_pkg::*;

    // Stage 2: weight products
    logic                    v2_reg;
    logic [IDX_W-1:0]        idx2_reg;
    logic                    last2_reg;
    logic [DX_W-1:0]         dx2_reg;
    logic signed [PR_W-1:0]  pax_reg, pbx_reg, pay_reg, pby_reg;
    logic signed [KX_W-1:0]  kx_reg;
    logic [KP_W-1:0]         ka, kb;

    // Stage 3: sums and reach product
    logic                    v3_reg;
    logic [IDX_W-1:0]        idx3_reg;
    logic                    last3_reg;
    logic signed [PS_W-1:0]  sumx_reg, sumy_reg;
    logic signed [DK_W-1:0]  dk_reg;

    // Stage 4: accumulators
    logic                    v4_reg;
    logic [IDX_W-1:0]        idx4_reg;
    logic                    last4_reg;
    logic signed [ACC_W-1:0] accx_reg, accy_reg;

    assign ka = KP_W'(issue.w2) * KP_W'(issue.fa);
    assign kb = KP_W'(issue.w3) * KP_W'(issue.fb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= issue.valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx2_reg  <= issue.idx;
        last2_reg <= issue.last;
        dx2_reg   <= issue.dx;
        pax_reg   <= PR_W'($signed({1'b0, issue.w_head})) * PR_W'(issue.s0x);
        pbx_reg   <= PR_W'($signed({1'b0, issue.w_tail})) * PR_W'(issue.s3x);
        pay_reg   <= PR_W'($signed({1'b0, issue.w_head})) * PR_W'(issue.s0y);
        pby_reg   <= PR_W'($signed({1'b0, issue.w_tail})) * PR_W'(issue.s3y);
        kx_reg    <= $signed({1'b0, ka}) - $signed({1'b0, kb});

        idx3_reg  <= idx2_reg;
        last3_reg <= last2_reg;
        sumx_reg  <= PS_W'(pax_reg) + PS_W'(pbx_reg);
        sumy_reg  <= PS_W'(pay_reg) + PS_W'(pby_reg);
        dk_reg    <= DK_W'($signed({1'b0, dx2_reg})) * DK_W'(kx_reg);

        idx4_reg  <= idx3_reg;
        last4_reg <= last3_reg;
        accx_reg  <= (ACC_W'(sumx_reg) <<< 8) + ACC_W'(dk_reg);
        accy_reg  <= ACC_W'(sumy_reg) <<< 8;
    end

    always_comb
    begin
        acc.valid = v4_reg;
        acc.idx   = idx4_reg;
        acc.last  = last4_reg;
        acc.acc_x = accx_reg;
        acc.acc_y = accy_reg;
    end

endmodule

`default_nettype wire

[rtl/lbf_round.sv]
// Output stage: round Q.24 sums to Q.8, saturate and register the result strobe.
// Depends on lbf_pkg for the accumulator and point types.
`default_nettype none

module lbf_round (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lbf_pkg::lbf_acc_t acc,
    output logic                   point_strobe,
    output lbf_pkg::lbf_point_t    point
);
    import lbf_pkg::*;

    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(COORD_MAX);
    localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(COORD_MIN);
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(32768);

    logic                      strobe_reg;
    lbf_point_t                point_reg, point_next;
    logic signed [ACC_W-1:0]   biased_x, biased_y;
    logic signed [RND_W-1:0]   rx, ry;

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [RND_W-1:0] v);
        if (v > SAT_HI)
            return COORD_W'(SAT_HI);
        else if (v < SAT_LO)
            return COORD_W'(SAT_LO);
        else
            return v[COORD_W-1:0];
    endfunction

    // Ties round toward +infinity: add a half, then floor.
    assign biased_x = acc.acc_x + HALF;
    assign biased_y = acc.acc_y + HALF;
    assign rx       = biased_x[ACC_W-1:16];
    assign ry       = biased_y[ACC_W-1:16];

    always_comb
    begin
        point_next.point_x     = sat(rx);
        point_next.point_y     = sat(ry);
        point_next.point_index = PIDX_W'(acc.idx);
        point_next.last_point  = acc.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= acc.valid;
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

    assign point_strobe = strobe_reg;
    assign point        = point_reg;

endmodule

`default_nettype wire

[rtl/link_bezier_flattener_unit.sv]
// Top level of the link Bezier flattener: sequencer, multiply pipeline, output rounding.
// Depends on lbf_pkg, lbf_seq, lbf_mac and lbf_round.
//
//   channel   signals                 direction  transfer
//   request   start, busy, link       in         start high and busy low at clk rise
//   result    point_strobe, point     out        one strobe per sample, no back-pressure
//
// Each request yields SEG_POINTS samples (16 as built), one per cycle; the next request is
// taken while the sequencer is idle or once its sample counter reaches the last sample.
// Busy drops during the last sample of a link, so the next link issues with no gap.
// A sample passes issue, two multiply stages, accumulate and round before it appears on
// point; the first sample of a request is issued from the registers loaded at acceptance.
// Reset clears the sequencer and all valid bits; data registers are not reset.
// The receiver cannot stall: the pipeline advances every cycle.
`default_nettype none

module link_bezier_flattener_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire lbf_pkg::lbf_link_t link,
    output logic                    busy,
    output logic                    point_strobe,
    output lbf_pkg::lbf_point_t     point
);
    import lbf_pkg::*;

    lbf_issue_t issue;
    lbf_acc_t   acc;

    // Hold the link's control data and issue samples in order.
    lbf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .link  (link),
        .busy  (busy),
        .issue (issue)
    );

    // Weighted sums: P1 and P2 folded into head/tail weights plus a dx reach term.
    lbf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue),
        .acc   (acc)
    );

    // Round to Q15.8, saturate, drive the strobe.
    lbf_round u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .point_strobe (point_strobe),
        .point        (point)
    );

endmodule

`default_nettype wire

[verif/lbf_sample_checker.sv]
`timescale 1ns / 1ps
// Sample checker for the link Bezier flattener: predicts every sample of each accepted
// request and compares the result channel against it in order. Depends on lbf_pkg.
module lbf_sample_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire lbf_pkg::lbf_link_t  link,
    input  wire logic                point_strobe,
    input  wire lbf_pkg::lbf_point_t point,
    output int                       mismatches,
    output int                       samples_due,
    output int                       samples_seen
);

    localparam int CW = lbf_pkg::COORD_W;
    localparam int IW = lbf_pkg::PIDX_W;

    lbf_pkg::lbf_point_t curve_samples[$];
    int err_count  = 0;
    int seen_count = 0;

    initial begin
        mismatches   = 0;
        samples_due  = 0;
        samples_seen = 0;
    end

    // num * 2^16 / cube, rounded to nearest with ties upward
    function automatic longint q16_weight(input longint num, input longint cube);
        longint q;
        longint r;
        q = (num * 65536) / cube;
        r = (num * 65536) % cube;
        if (2 * r >= cube)
            q = q + 1;
        return q;
    endfunction

    // Q.24 sum down to Q.8, ties toward +inf, clamped to the coordinate range
    function automatic longint q8_clamp(input longint acc);
        longint r;
        r = (acc + 64'sd32768) >>> 16;
        if (r > lbf_pkg::COORD_MAX)
            r = lbf_pkg::COORD_MAX;
        if (r < lbf_pkg::COORD_MIN)
            r = lbf_pkg::COORD_MIN;
        return r;
    endfunction

    function automatic void predict_curve(input lbf_pkg::lbf_link_t req);
        longint n, cube, t, u;
        longint w1, w2, w3, w4;
        longint span, p0x, p0y, p1x, p2x, p3x, p3y, ax, ay;
        lbf_pkg::lbf_point_t s;
        n    = lbf_pkg::SEG_POINTS - 1;
        cube = n * n * n;
        span = longint'($signed(req.end_x)) - longint'($signed(req.start_x));
        if (span < 0)
            span = -span;
        // control points at full width, Q.8
        p0x = (longint'($signed(req.start_x)) + longint'($signed(req.shift_x))) * 256;
        p0y = (longint'($signed(req.start_y)) + longint'($signed(req.shift_y))) * 256;
        p3x = (longint'($signed(req.end_x)) + longint'($signed(req.shift_x))) * 256;
        p3y = (longint'($signed(req.end_y)) + longint'($signed(req.shift_y))) * 256;
        p1x = p0x + span * longint'(req.start_reach);
        p2x = p3x - span * longint'(req.end_reach);
        for (int i = 0; i < lbf_pkg::SEG_POINTS; i++) begin
            t  = i;
            u  = n - t;
            w1 = q16_weight(u * u * u, cube);
            w2 = q16_weight(3 * u * u * t, cube);
            w3 = q16_weight(3 * u * t * t, cube);
            w4 = q16_weight(t * t * t, cube);
            ax = w1 * p0x + w2 * p1x + w3 * p2x + w4 * p3x;
            // control points only move in x, so y blends the two end points
            ay = (w1 + w2) * p0y + (w3 + w4) * p3y;
            s.point_x     = CW'(q8_clamp(ax));
            s.point_y     = CW'(q8_clamp(ay));
            s.point_index = IW'(i);
            s.last_point  = (t == n);
            curve_samples.insert(curve_samples.size(), s);
        end
    endfunction

    task automatic check_field(input string name, input int idx,
                               input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s of sample %0d: expected %0d, got %0d",
                     $time, name, idx, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk) begin
        lbf_pkg::lbf_point_t want;
        if (rst_n) begin
            // retire the oldest sample before queuing a newly accepted request
            if (point_strobe === 1'b1) begin
                seen_count++;
                if (curve_samples.size() == 0) begin
                    $display("%0t: unexpected sample: expected none, got x=%0d y=%0d idx=%0d",
                             $time, $signed(point.point_x), $signed(point.point_y),
                             point.point_index);
                    err_count++;
                end else begin
                    want = curve_samples.pop_front();
                    check_field("point_x", want.point_index,
                                $signed(want.point_x), $signed(point.point_x));
                    check_field("point_y", want.point_index,
                                $signed(want.point_y), $signed(point.point_y));
                    check_field("point_index", want.point_index,
                                want.point_index, point.point_index);
                    check_field("last_point", want.point_index,
                                want.last_point, point.last_point);
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                predict_curve(link);
        end
        mismatches   <= err_count;
        samples_seen <= seen_count;
        samples_due  <= curve_samples.size();
    end

endmodule

[verif/tb_link_bezier_flattener_unit.sv]
`timescale 1ns / 1ps
// Testbench top for link_bezier_flattener_unit: drives link requests and gives the verdict.
// Depends on lbf_pkg, the block itself and lbf_sample_checker.
module tb_link_bezier_flattener_unit;

    localparam int CW           = lbf_pkg::COORD_W;
    localparam int FW           = lbf_pkg::FACT_W;
    localparam int CMAX         = lbf_pkg::COORD_MAX;
    localparam int CMIN         = lbf_pkg::COORD_MIN;
    localparam int RANDOM_LINKS = 500;
    localparam int CALM_TAIL    = 100;     // final requests sent back to back
    localparam int DRAIN_AT     = 250;     // request index where the sender drains
    localparam int FLUSH_CYCLES = 10;      // margin past the sample pipeline
    // Hang guard, set far above the slowest run of ~516 links with their idle gaps.
    localparam int CYCLE_LIMIT  = 200000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                point_strobe;
    lbf_pkg::lbf_link_t  link;
    lbf_pkg::lbf_point_t point;

    int mismatches;
    int samples_due;
    int samples_seen;
    int links_sent = 0;
    int cycles     = 0;

    link_bezier_flattener_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .link         (link),
        .busy         (busy),
        .point_strobe (point_strobe),
        .point        (point)
    );

    lbf_sample_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .link         (link),
        .point_strobe (point_strobe),
        .point        (point),
        .mismatches   (mismatches),
        .samples_due  (samples_due),
        .samples_seen (samples_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_link_bezier_flattener_unit NOT OK");
            $finish;
        end
    end

    function automatic lbf_pkg::lbf_link_t make_link(input int sx, input int sy,
                                                      input int ex, input int ey,
                                                      input int hx, input int hy,
                                                      input int fa, input int fb);
        lbf_pkg::lbf_link_t req;
        req.start_x     = CW'(sx);
        req.start_y     = CW'(sy);
        req.end_x       = CW'(ex);
        req.end_y       = CW'(ey);
        req.shift_x     = CW'(hx);
        req.shift_y     = CW'(hy);
        req.start_reach = FW'(fa);
        req.end_reach   = FW'(fb);
        return req;
    endfunction

    // Mostly moderate coordinates, with full-range values and values hugging the rails.
    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return CW'($urandom);
            8:       return CW'(CMAX - int'($urandom_range(0, 255)));
            9:       return CW'(CMIN + int'($urandom_range(0, 255)));
            default: return CW'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    // Mostly 0..1.0, sometimes past 1.0 up to the full 9-bit range.
    function automatic logic [FW-1:0] rand_factor();
        if ($urandom_range(0, 4) == 0)
            return FW'($urandom_range(0, 511));
        return FW'($urandom_range(0, 256));
    endfunction

    // Present one request and hold it until the block takes it. Busy is read before
    // the edge updates it, so a low value here means the request went in at this edge.
    task automatic send_link(input lbf_pkg::lbf_link_t req);
        start <= 1'b1;
        link  <= req;
        do @(posedge clk); while (busy !== 1'b0);
        links_sent++;
    endtask

    // Drop start for a burst of idle cycles.
    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drop start and wait until every predicted sample has been checked.
    task automatic drain_samples();
        start <= 1'b0;
        do @(posedge clk); while (samples_due != 0);
    endtask

    initial begin
        lbf_pkg::lbf_link_t req;

        rst_n = 1'b0;
        start = 1'b0;
        link  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: plain links, reversed links, zero and over-unity factors,
        // coordinates and offsets at the rails, and rounding on odd fractions.
        send_link(make_link(0, 0, 0, 0, 0, 0, 0, 0));
        send_link(make_link(0, 0, 100 * 256, 40 * 256, 0, 0, 128, 128));
        send_link(make_link(50 * 256, 10 * 256, -50 * 256, -30 * 256, 7, -9, 256, 256));
        send_link(make_link(CMIN, CMIN, CMAX, CMAX, 0, 0, 256, 256));
        send_link(make_link(CMIN, CMAX, CMAX, CMIN, 0, 0, 511, 511));
        idle_for(3);
        send_link(make_link(-300 * 256, 0, 200 * 256, 5, 0, 0, 257, 0));
        send_link(make_link(10, 20, -4000, 30, 0, 0, 0, 511));
        // offsets that push start and end past the positive and negative rails
        send_link(make_link(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 256, 256));
        send_link(make_link(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 256, 256));
        send_link(make_link(CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, 511, 256));
        send_link(make_link(CMAX - 256, 0, CMAX, 1000, 512, -512, 384, 300));
        // no horizontal distance: inner control points sit on the end points
        send_link(make_link(1000, -5000, 1000, 7000, 0, 0, 256, 256));
        send_link(make_link(1, -1, 3, 2, 0, 0, 1, 255));
        send_link(make_link(-1, 0, 0, -1, -1, 1, 511, 511));
        send_link(make_link(CMIN, 0, CMIN + 1, 1, 0, 0, 511, 1));
        send_link(make_link(12345, -6789, -23456, 34567, -1111, 2222, 99, 173));

        // Random part: bursty sender gaps through most of the run, one full drain,
        // and a gap-free tail.
        for (int k = 0; k < RANDOM_LINKS; k++) begin
            if (k == DRAIN_AT)
                drain_samples();
            else if (k < RANDOM_LINKS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 12));
            req.start_x     = rand_coord();
            req.start_y     = rand_coord();
            req.end_x       = rand_coord();
            req.end_y       = rand_coord();
            req.shift_x     = rand_coord();
            req.shift_y     = rand_coord();
            req.start_reach = rand_factor();
            req.end_reach   = rand_factor();
            send_link(req);
        end

        // Wait out every pending sample, then a few more cycles for strays.
        drain_samples();
        repeat (FLUSH_CYCLES) @(posedge clk);

        $display("Ran %0d links and compared %0d samples, including saturating offsets,",
                 links_sent, samples_seen);
        $display("over-unity factors, reversed links, random sender gaps and a mid-run drain.");
        if (mismatches == 0 && samples_due == 0)
            $display("tb_link_bezier_flattener_unit OK");
        else
            $display("tb_link_bezier_flattener_unit NOT OK");
        $finish;
    end

endmodule
